// ===== src/sms_pkg.sv =====
// Shared constants and types for the subarray minimum sum block.
// No dependencies; every other file of the block but sms_stack_ram imports this package.
`timescale 1ns / 1ps

package sms_pkg;

    localparam int SMS_MAX_LEN = 4096;
    localparam int VALUE_BITS  = 16;
    localparam int TOTAL_W     = 30;
    // Width reserved for the distance; wider than the distance needs at the largest supported sequence length.
    localparam int MAX_DIST_W  = 17;
    localparam int PROD_W      = VALUE_BITS + MAX_DIST_W;

    localparam logic [TOTAL_W-1:0] MODULUS = 30'd1000000007;

    // Step strobes from the sequencer to the modular arithmetic unit.
    typedef struct packed {
        logic mul;
        logic reduce;
        logic correct;
        logic fold;
        logic add;
        logic clear;
    } sms_acc_ctrl_t;

endpackage

// ===== src/sms_stack_ram.sv =====
// Synchronous stack memory: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module sms_stack_ram #(
    parameter int DATA_W = 76,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/sms_accum.sv =====
// Modular arithmetic unit: product, reduction modulo 1e9+7, partial and grand sums.
// Depends on sms_pkg for widths, the modulus and the step strobe struct.
`timescale 1ns / 1ps

module sms_accum
    import sms_pkg::*;
#(
    parameter int DIST_W = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sms_acc_ctrl_t         ctrl,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [DIST_W-1:0]     distance,
    input  logic [TOTAL_W-1:0]    partial,
    output logic [TOTAL_W-1:0]    part,
    output logic [TOTAL_W-1:0]    grand
);

    localparam int QUOT_W = PROD_W - TOTAL_W;

    logic [PROD_W-1:0]  prod_reg;
    logic [TOTAL_W:0]   red_reg;
    logic [TOTAL_W-1:0] corr_reg;
    logic [TOTAL_W-1:0] part_reg;
    logic [TOTAL_W-1:0] grand_reg;

    logic [QUOT_W-1:0]  quot;
    logic [PROD_W-1:0]  quot_times_m;
    logic [PROD_W-1:0]  red_full;
    logic [TOTAL_W:0]   red_next;
    logic [TOTAL_W-1:0] corr_next;
    logic [TOTAL_W-1:0] part_next;
    logic [TOTAL_W-1:0] grand_next;

    function automatic logic [TOTAL_W-1:0] add_mod(input logic [TOTAL_W-1:0] a,
                                                    input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS}) begin
            s = s - {1'b0, MODULUS};
        end
        return s[TOTAL_W-1:0];
    endfunction

    // The top bits of the product underestimate the quotient, so the
    // remainder left after one constant multiply stays below twice the modulus.
    assign quot         = prod_reg[PROD_W-1:TOTAL_W];
    assign quot_times_m = PROD_W'(quot) * PROD_W'(MODULUS);
    assign red_full     = prod_reg - quot_times_m;
    assign red_next     = red_full[TOTAL_W:0];
    assign corr_next    = (red_reg >= {1'b0, MODULUS}) ?
                          TOTAL_W'(red_reg - {1'b0, MODULUS}) : red_reg[TOTAL_W-1:0];
    assign part_next    = add_mod(partial, corr_reg);
    assign grand_next   = add_mod(grand_reg, part_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.mul) begin
            prod_reg <= PROD_W'(value) * PROD_W'(distance);
        end
        if (ctrl.reduce) begin
            red_reg <= red_next;
        end
        if (ctrl.correct) begin
            corr_reg <= corr_next;
        end
        if (ctrl.fold) begin
            part_reg <= part_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grand_reg <= '0;
        end else if (ctrl.clear) begin
            grand_reg <= '0;
        end else if (ctrl.add) begin
            grand_reg <= grand_next;
        end
    end

    assign part  = part_reg;
    assign grand = grand_reg;

endmodule

// ===== src/subarray_minimum_sum_top.sv =====
// Channel   Dir  Ports                          Meaning
// s_        in   s_valid s_ready s_value s_last one element of the sequence per item
// m_        out  m_valid m_ready m_total         one result item per sequence,
//                m_overflow                      on the item that carries last
//
// An element passes the idle, scan, reduce, correct, fold and push states. Each pop
// rescans, and a pop that leaves entries behind first waits on the registered read of the
// entry below the cached top of stack; the modular product goes through three register
// steps before the push. An element beyond MAX_LEN is only flagged. A closing item then
// goes to the result register, waiting while an earlier result is still not taken.
// Reset is synchronous, active low; the stack memory needs no clearing pass.
// Depends on sms_pkg, sms_stack_ram and sms_accum.
`timescale 1ns / 1ps

module subarray_minimum_sum_top
    import sms_pkg::*;
#(
    parameter int MAX_LEN = SMS_MAX_LEN
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    input  logic                  s_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [TOTAL_W-1:0]    m_total,
    output logic                  m_overflow
);

    localparam int POS_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int ENTRY_W = VALUE_BITS + POS_W + TOTAL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_REDUCE,
        ST_CORRECT,
        ST_FOLD,
        ST_PUSH,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   height_reg, height_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               too_long_reg, too_long_next;
    logic               m_valid_reg, m_valid_next;
    logic [TOTAL_W-1:0] m_total_reg, m_total_next;
    logic               m_overflow_reg, m_overflow_next;

    logic [VALUE_BITS-1:0] value_reg;
    logic                  last_reg;
    logic [VALUE_BITS-1:0] top_value_reg;
    logic [POS_W-1:0]      top_pos_reg;
    logic [TOTAL_W-1:0]    top_partial_reg;

    logic               accept;
    logic               has_top;
    logic               load_top;
    logic               push;
    logic [CNT_W-1:0]   distance;
    logic [TOTAL_W-1:0] partial;
    logic [TOTAL_W-1:0] part;
    logic [TOTAL_W-1:0] grand;
    sms_acc_ctrl_t      ctrl;

    logic               rd_en;
    logic [POS_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;
    logic [CNT_W-1:0]   below_top;

    assign accept    = s_valid && s_ready;
    assign has_top   = (height_reg != '0);
    assign distance  = has_top ? (count_reg - CNT_W'(top_pos_reg)) : (count_reg + CNT_W'(1));
    assign partial   = has_top ? top_partial_reg : '0;
    assign below_top = height_reg - CNT_W'(2);
    assign rd_addr   = below_top[POS_W-1:0];
    assign wr_data   = {value_reg, count_reg[POS_W-1:0], part};

    always_comb begin
        state_next      = state_reg;
        height_next     = height_reg;
        count_next      = count_reg;
        too_long_next   = too_long_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_total_next    = m_total_reg;
        m_overflow_next = m_overflow_reg;
        ctrl            = '0;
        rd_en           = 1'b0;
        load_top        = 1'b0;
        push            = 1'b0;
        s_ready         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (count_reg >= CNT_W'(MAX_LEN)) begin
                        too_long_next = 1'b1;
                        state_next    = s_last ? ST_FINISH : ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Pop every entry not smaller than the new element.
                if (has_top && (top_value_reg >= value_reg)) begin
                    height_next = height_reg - CNT_W'(1);
                    if (height_reg > CNT_W'(1)) begin
                        rd_en      = 1'b1;
                        state_next = ST_LOAD;
                    end
                end else begin
                    ctrl.mul   = 1'b1;
                    state_next = ST_REDUCE;
                end
            end
            ST_LOAD: begin
                load_top   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_REDUCE: begin
                ctrl.reduce = 1'b1;
                state_next  = ST_CORRECT;
            end
            ST_CORRECT: begin
                ctrl.correct = 1'b1;
                state_next   = ST_FOLD;
            end
            ST_FOLD: begin
                ctrl.fold  = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                ctrl.add    = 1'b1;
                push        = 1'b1;
                height_next = height_reg + CNT_W'(1);
                count_next  = count_reg + CNT_W'(1);
                state_next  = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_total_next    = too_long_reg ? '0 : grand;
                    m_overflow_next = too_long_reg;
                    ctrl.clear      = 1'b1;
                    height_next     = '0;
                    count_next      = '0;
                    too_long_next   = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            height_reg     <= '0;
            count_reg      <= '0;
            too_long_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_total_reg    <= '0;
            m_overflow_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            height_reg     <= height_next;
            count_reg      <= count_next;
            too_long_reg   <= too_long_next;
            m_valid_reg    <= m_valid_next;
            m_total_reg    <= m_total_next;
            m_overflow_reg <= m_overflow_next;
        end
    end

    // The top of stack is cached so the compare needs no memory read.
    always_ff @(posedge aclk) begin
        if (accept) begin
            value_reg <= s_value;
            last_reg  <= s_last;
        end
        if (load_top) begin
            {top_value_reg, top_pos_reg, top_partial_reg} <= rd_data;
        end else if (push) begin
            {top_value_reg, top_pos_reg, top_partial_reg} <= wr_data;
        end
    end

    sms_stack_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (MAX_LEN),
        .ADDR_W (POS_W)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (push),
        .wr_addr (height_reg[POS_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sms_accum #(
        .DIST_W (CNT_W)
    ) u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .value    (value_reg),
        .distance (distance),
        .partial  (partial),
        .part     (part),
        .grand    (grand)
    );

    assign m_valid    = m_valid_reg;
    assign m_total    = m_total_reg;
    assign m_overflow = m_overflow_reg;

endmodule

// ===== src/sms_checker.sv =====
// Port-level checks for the subarray minimum sum block, bound to its top level.
// Depends on sms_pkg for widths and the modulus.
`timescale 1ns / 1ps

module sms_checker
    import sms_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [VALUE_BITS-1:0] s_value,
    input logic                  s_last,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [TOTAL_W-1:0]    m_total,
    input logic                  m_overflow
);

    // An item that does not close its sequence never brings out a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_last) |=> !$rose(m_valid))
        else $error("result appeared after an item without last");

    // A closing item keeps the input side busy in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> !s_ready)
        else $error("input ready right after a closing item");

    // A result is always reduced, and an overflowed sequence reports zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_total < MODULUS) && (!m_overflow || (m_total == '0))))
        else $error("result total out of range");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_total) && $stable(m_overflow)))
        else $error("stalled result changed");

endmodule

bind subarray_minimum_sum_top sms_checker u_sms_checker (.*);
